@@ src/csld_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package csld_pkg;

    localparam int ELEM_W = 16;
    localparam int ACC_W  = 48;
    localparam int ROOT_W = 32;
    localparam int DEN_W  = 64;
    localparam int MAG_W  = 21;
    localparam int DEC_W  = 33;

    localparam logic [15:0] DECAY_RATE_RESET     = 16'd7864;
    localparam logic [15:0] KEEP_THRESHOLD_RESET = 16'd0;

    localparam logic [0:0] REG_DECAY_RATE     = 1'b0;
    localparam logic [0:0] REG_KEEP_THRESHOLD = 1'b1;

    localparam logic signed [ACC_W-1:0] DOT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] DOT_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] NORM_MAX = {ACC_W{1'b1}};
    localparam logic [MAG_W-1:0] QUO_CAP = 21'h100000;

    // Request from the accumulator front end to the finishing sequencer.
    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        norm_a;
        logic [ACC_W-1:0]        norm_b;
        logic [15:0]             lbl_dist;
    } fin_req_t;

    // Q0.32 factors exp(-2^(b-16)).
    function automatic logic [31:0] decay_factor(input logic [4:0] b);
        logic [31:0] f;
        begin
            case (b)
                5'd0:  f = 32'd4294901760;
                5'd1:  f = 32'd4294836226;
                5'd2:  f = 32'd4294705160;
                5'd3:  f = 32'd4294443040;
                5'd4:  f = 32'd4293918848;
                5'd5:  f = 32'd4292870656;
                5'd6:  f = 32'd4290775039;
                5'd7:  f = 32'd4286586875;
                5'd8:  f = 32'd4278222805;
                5'd9:  f = 32'd4261543595;
                5'd10: f = 32'd4228380000;
                5'd11: f = 32'd4162825044;
                5'd12: f = 32'd4034748382;
                5'd13: f = 32'd3790295335;
                5'd14: f = 32'd3344923893;
                5'd15: f = 32'd2605029347;
                5'd16: f = 32'd1580030169;
                5'd17: f = 32'd581260615;
                5'd18: f = 32'd78665070;
                5'd19: f = 32'd1440800;
                5'd20: f = 32'd483;
                default: f = 32'd0;
            endcase
            return f;
        end
    endfunction

endpackage
`default_nettype wire

@@ src/cosine_similarity_label_decay.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake           Payload
// s_axis    in         s_tvalid/s_tready   tdata, tlast (last_pair)
// m_axis    out        m_tvalid/m_tready   tdata, tuser
// cfg       in         cfg_we              cfg_index, cfg_data
// A pair that is not last adds its product, then both squares.
// A last pair then runs the finishing sequencer: two norm shift/root passes,
// a bit-serial divide and the decay steps.
// Reset is synchronous; the input is not ready while the sequencer is busy,
// and a last pair does not start the sequencer while a result still waits
// in the output register.
module cosine_similarity_label_decay (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // first_element[15:0], second_element[31:16], first_label[47:32], second_label[63:48]
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // similarity[15:0]
    output logic [15:0]      m_tdata,
    // edge_kept[0], zero_norm[1]
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    typedef enum logic [2:0] {T_IDLE, T_SQ, T_LAST, T_FIN, T_HOLD} top_t;
    top_t state_reg;
    logic [15:0] rate_reg, thr_reg;
    logic [15:0] ea_reg, eb_reg, dist_reg;
    logic step, phase, clr, start, done, kept, zn;
    logic signed [15:0] sim;
    csld_pkg::fin_req_t sums, req;

    assign s_tready = (state_reg == T_IDLE);
    assign step  = (state_reg == T_SQ) || (state_reg == T_LAST) ||
                   ((state_reg == T_IDLE) && s_tvalid);
    assign phase = (state_reg != T_IDLE);
    assign start = (state_reg == T_FIN) && !done && !m_tvalid;
    assign clr   = 1'b0;

    always_comb begin
        req = sums;
        req.lbl_dist = dist_reg;
    end

    csld_acc u_acc (
        .aclk(aclk), .aresetn(aresetn), .step(step), .phase(phase),
        .clear(clr || (done && state_reg == T_HOLD)),
        .elem_a(phase ? $signed(ea_reg) : $signed(s_tdata[15:0])),
        .elem_b(phase ? $signed(eb_reg) : $signed(s_tdata[31:16])),
        .sums(sums)
    );

    csld_fin u_fin (
        .aclk(aclk), .aresetn(aresetn), .start(start), .req(req),
        .decay_rate(rate_reg), .keep_threshold(thr_reg), .done(done),
        .similarity(sim), .edge_kept(kept), .zero_norm(zn)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            rate_reg <= csld_pkg::DECAY_RATE_RESET;
            thr_reg <= csld_pkg::KEEP_THRESHOLD_RESET;
            m_tvalid <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    csld_pkg::REG_DECAY_RATE:     rate_reg <= cfg_data;
                    csld_pkg::REG_KEEP_THRESHOLD: thr_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            unique case (state_reg)
                T_IDLE: if (s_tvalid) begin
                    ea_reg <= s_tdata[15:0];
                    eb_reg <= s_tdata[31:16];
                    dist_reg <= (s_tdata[47:32] > s_tdata[63:48])
                              ? s_tdata[47:32] - s_tdata[63:48]
                              : s_tdata[63:48] - s_tdata[47:32];
                    state_reg <= s_tlast ? T_LAST : T_SQ;
                end
                T_SQ:   state_reg <= T_IDLE;
                T_LAST: state_reg <= T_FIN;
                T_FIN:  if (start) state_reg <= T_HOLD;
                T_HOLD: if (done) begin
                    m_tdata <= sim;
                    m_tuser <= {zn, kept};
                    m_tvalid <= 1'b1;
                    state_reg <= T_IDLE;
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/csld_acc.sv @@
`timescale 1ns / 1ps
`default_nettype none
module csld_acc (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   step,
    input  wire logic                   phase,
    input  wire logic                   clear,
    input  wire logic signed [15:0]     elem_a,
    input  wire logic signed [15:0]     elem_b,
    output csld_pkg::fin_req_t          sums
);
    // Phase 0 adds the product a*b; phase 1 adds both squares.
    logic signed [31:0] prod;
    logic signed [15:0] mul_x, mul_y;
    logic signed [31:0] sq_b;
    logic signed [csld_pkg::ACC_W+1:0] dsum;
    logic [csld_pkg::ACC_W:0] nsum_a, nsum_b;
    logic signed [csld_pkg::ACC_W-1:0] dot_reg;
    logic [csld_pkg::ACC_W-1:0] na_reg, nb_reg;

    assign mul_x = phase ? elem_a : elem_a;
    assign mul_y = phase ? elem_a : elem_b;
    assign prod  = mul_x * mul_y;
    assign sq_b  = elem_b * elem_b;
    assign dsum  = {{2{dot_reg[csld_pkg::ACC_W-1]}}, dot_reg}
                 + {{(csld_pkg::ACC_W-30){prod[31]}}, prod};
    assign nsum_a = {1'b0, na_reg} + {{(csld_pkg::ACC_W-31){1'b0}}, prod[31:0]};
    assign nsum_b = {1'b0, nb_reg} + {{(csld_pkg::ACC_W-31){1'b0}}, sq_b[31:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end else if (step) begin
            if (!phase) begin
                if (dsum > $signed({2'b00, csld_pkg::DOT_MAX}))
                    dot_reg <= csld_pkg::DOT_MAX;
                else if (dsum < $signed({2'b11, csld_pkg::DOT_MIN}))
                    dot_reg <= csld_pkg::DOT_MIN;
                else
                    dot_reg <= dsum[csld_pkg::ACC_W-1:0];
            end else begin
                na_reg <= nsum_a[csld_pkg::ACC_W] ? csld_pkg::NORM_MAX
                                                  : nsum_a[csld_pkg::ACC_W-1:0];
                nb_reg <= nsum_b[csld_pkg::ACC_W] ? csld_pkg::NORM_MAX
                                                  : nsum_b[csld_pkg::ACC_W-1:0];
            end
        end
    end

    assign sums.dot      = dot_reg;
    assign sums.norm_a   = na_reg;
    assign sums.norm_b   = nb_reg;
    assign sums.lbl_dist = '0;
endmodule
`default_nettype wire

@@ src/csld_fin.sv @@
`timescale 1ns / 1ps
`default_nettype none
module csld_fin (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  csld_pkg::fin_req_t       req,
    input  wire logic [15:0]         decay_rate,
    input  wire logic signed [15:0]  keep_threshold,
    output logic                     done,
    output logic signed [15:0]       similarity,
    output logic                     edge_kept,
    output logic                     zero_norm
);
    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SQRT, S_NEXT, S_DEN, S_DIV, S_DXM, S_DEC, S_DECM,
        S_FMUL, S_OUT
    } state_t;

    state_t state_reg;
    logic [63:0] nv_reg, rem_reg, res_reg, bit_reg, den_reg, drem_reg;
    logic [5:0] k_reg, ksum_reg;
    logic [6:0] cnt_reg;
    logic       which_reg, neg_reg;
    logic [31:0] root_a_reg;
    logic [csld_pkg::MAG_W-1:0] mag_reg;
    logic [31:0] x_reg;
    logic [4:0]  b_reg;
    logic [csld_pkg::DEC_W-1:0] dec_reg;
    logic [63:0] prod_reg;
    logic [15:0] dist_reg;
    logic [csld_pkg::ACC_W-1:0] norm_b_reg;

    // One shared 64-bit subtractor serves the root and divide phases; one 33x32 multiplier serves the products.
    logic [63:0] trial;
    logic [64:0] diff;
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mprod;
    logic [64:0] rem_sh;
    logic [csld_pkg::MAG_W-1:0] mag_sh;
    logic [47:0] absdot;
    logic [21:0] smag;
    logic signed [16:0] sim_s;

    assign trial  = res_reg + bit_reg;
    assign rem_sh = {rem_reg, 1'b0};
    assign mag_sh = {mag_reg[csld_pkg::MAG_W-2:0], 1'b0};
    always_comb begin
        diff  = (state_reg == S_DIV) ? rem_sh - {1'b0, den_reg} : {1'b0, nv_reg} - {1'b0, trial};
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DEN:  begin mul_a = {1'b0, root_a_reg}; mul_b = res_reg[31:0]; end
            S_DXM:  begin mul_a = {17'd0, dist_reg}; mul_b = {16'd0, decay_rate}; end
            S_DECM: begin
                mul_a = dec_reg;
                mul_b = csld_pkg::decay_factor(b_reg);
            end
            S_FMUL: begin mul_a = {12'd0, mag_reg}; mul_b = dec_reg[31:0]; end
            default: ;
        endcase
        mprod = mul_a * {1'b0, mul_b};
        absdot = req.dot[47] ? 48'd0 - req.dot : req.dot;
        smag = dec_reg[32] ? {1'b0, mag_reg} : {1'b0, prod_reg[52:32]};
        if (neg_reg)
            sim_s = (smag > 22'd32768) ? -17'sd32768 : -$signed({1'b0, smag[15:0]});
        else
            sim_s = (smag > 22'd32767) ? 17'sd32767 : $signed({1'b0, smag[15:0]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (start) begin
                    neg_reg <= req.dot[47];
                    rem_reg <= {16'd0, absdot};
                    dist_reg <= req.lbl_dist;
                    norm_b_reg <= req.norm_b;
                    if (req.norm_a == '0 || req.norm_b == '0) begin
                        similarity <= '0;
                        edge_kept <= 1'b0;
                        zero_norm <= 1'b1;
                        done <= 1'b1;
                    end else begin
                        nv_reg <= {16'd0, req.norm_a};
                        k_reg <= '0;
                        ksum_reg <= '0;
                        which_reg <= 1'b0;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (nv_reg[63:60] == 4'd0) begin
                        nv_reg <= nv_reg << 2;
                        k_reg <= k_reg + 6'd1;
                    end else begin
                        res_reg <= '0;
                        bit_reg <= 64'h4000_0000_0000_0000;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (!diff[64]) begin
                        nv_reg <= diff[63:0];
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) state_reg <= S_NEXT;
                end
                S_NEXT: begin
                    ksum_reg <= ksum_reg + k_reg;
                    k_reg <= '0;
                    if (!which_reg) begin
                        root_a_reg <= res_reg[31:0];
                        which_reg <= 1'b1;
                        nv_reg <= {16'd0, norm_b_reg};
                        state_reg <= S_NORM;
                    end else begin
                        state_reg <= S_DEN;
                    end
                end
                S_DEN: begin
                    den_reg <= mprod[63:0];
                    mag_reg <= '0;
                    cnt_reg <= {1'b0, ksum_reg} + 7'd15;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (cnt_reg == 7'd0) begin
                        state_reg <= S_DXM;
                    end else begin
                        logic [csld_pkg::MAG_W-1:0] m;
                        m = mag_sh;
                        if (!diff[64]) begin
                            rem_reg <= diff[63:0];
                            m[0] = 1'b1;
                        end else begin
                            rem_reg <= rem_sh[63:0];
                        end
                        cnt_reg <= cnt_reg - 7'd1;
                        if (m >= csld_pkg::QUO_CAP) begin
                            mag_reg <= csld_pkg::QUO_CAP;
                            state_reg <= S_DXM;
                        end else begin
                            mag_reg <= m;
                        end
                    end
                end
                S_DXM: begin
                    x_reg <= mprod[31:0];
                    dec_reg <= 33'h1_0000_0000;
                    b_reg <= '0;
                    state_reg <= S_DEC;
                end
                S_DEC: begin
                    if (x_reg[31:21] != '0) begin
                        dec_reg <= '0;
                        state_reg <= S_FMUL;
                    end else if (b_reg == 5'd21) begin
                        state_reg <= S_FMUL;
                    end else if (x_reg[b_reg]) begin
                        state_reg <= S_DECM;
                    end else begin
                        b_reg <= b_reg + 5'd1;
                    end
                end
                S_DECM: begin
                    dec_reg <= mprod[64:32] + {32'd0, mprod[31]};
                    b_reg <= b_reg + 5'd1;
                    state_reg <= S_DEC;
                end
                S_FMUL: begin
                    prod_reg <= mprod[63:0];
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (sim_s[15:0] == 16'd0 || $signed(sim_s[15:0]) < keep_threshold) begin
                        similarity <= '0;
                        edge_kept <= 1'b0;
                    end else begin
                        similarity <= sim_s[15:0];
                        edge_kept <= 1'b1;
                    end
                    zero_norm <= 1'b0;
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ tb/tb_cosine_similarity_label_decay.sv @@
`timescale 1ns / 1ps
module tb_cosine_similarity_label_decay;

    typedef struct packed {
        logic        last;
        logic [15:0] label_b;
        logic [15:0] label_a;
        logic [15:0] elem_b;
        logic [15:0] elem_a;
    } pair_t;

    typedef struct packed {
        logic [15:0] sim;
        logic        kept;
        logic        zero_norm;
    } score_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = csld_pkg::REG_DECAY_RATE;
    logic [15:0] cfg_data = '0;

    cosine_similarity_label_decay dut (.*);

    always #2 aclk = ~aclk;

    // Q0.32 factors exp(-2^(b-16)), one per bit of the scaled label distance.
    localparam logic [31:0] EXP_STEP [21] = '{
        32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
        32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440800,
        32'd483
    };

    pair_t       pending_pairs[$];
    score_t      expected_scores[$];
    pair_t       cur_pair;
    logic [15:0] alpha = csld_pkg::DECAY_RATE_RESET;
    logic signed [15:0] thresh = csld_pkg::KEEP_THRESHOLD_RESET;
    longint      dot_acc;
    logic [63:0] norm_a_acc, norm_b_acc;
    int          send_idle, recv_idle;
    int          errors = 0;
    int          quiet_cycles = 0;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Normalise into [2^60, 2^62) by even shifts, so the root carries 2^k.
    function automatic logic [63:0] scaled_root(input logic [63:0] n, output int k);
        k = 0;
        while (n < (64'd1 << 60)) begin
            n = n << 2;
            k++;
        end
        return int_sqrt(n);
    endfunction

    function automatic logic [63:0] label_decay(input logic [31:0] x);
        logic [63:0] acc;
        acc = 64'd1 << 32;
        if ((x >> 21) != 0) return 64'd0;
        for (int b = 0; b < 21; b++)
            if (x[b]) acc = (acc * EXP_STEP[b] + (64'd1 << 31)) >> 32;
        return acc;
    endfunction

    task automatic accumulate_pair(input pair_t p);
        longint a, b;
        logic [63:0] den, rem, mag;
        logic [31:0] lbl_dist;
        longint sim;
        int k1, k2;
        logic neg;
        score_t s;
        a = longint'($signed(p.elem_a));
        b = longint'($signed(p.elem_b));
        dot_acc += a * b;
        if (dot_acc > 64'sh7FFF_FFFF_FFFF) dot_acc = 64'sh7FFF_FFFF_FFFF;
        if (dot_acc < -64'sh8000_0000_0000) dot_acc = -64'sh8000_0000_0000;
        norm_a_acc += a * a;
        if (norm_a_acc > 64'hFFFF_FFFF_FFFF) norm_a_acc = 64'hFFFF_FFFF_FFFF;
        norm_b_acc += b * b;
        if (norm_b_acc > 64'hFFFF_FFFF_FFFF) norm_b_acc = 64'hFFFF_FFFF_FFFF;
        if (!p.last) return;
        if (norm_a_acc == 0 || norm_b_acc == 0) begin
            s = '{sim: 16'd0, kept: 1'b0, zero_norm: 1'b1};
        end else begin
            den = scaled_root(norm_a_acc, k1);
            den = den * scaled_root(norm_b_acc, k2);
            neg = dot_acc < 0;
            rem = neg ? -dot_acc : dot_acc;
            mag = 0;
            for (int i = 0; i < k1 + k2 + 15; i++) begin
                rem = rem << 1;
                mag = mag << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    mag[0] = 1'b1;
                end
                if (mag >= 64'd1 << 20) begin
                    mag = 64'd1 << 20;
                    break;
                end
            end
            lbl_dist = p.label_a > p.label_b ? p.label_a - p.label_b
                                             : p.label_b - p.label_a;
            mag = (mag * label_decay(alpha * lbl_dist)) >> 32;
            sim = neg ? -longint'(mag) : longint'(mag);
            if (sim > 32767) sim = 32767;
            if (sim < -32768) sim = -32768;
            if (sim < thresh) sim = 0;
            s = '{sim: sim[15:0], kept: sim != 0, zero_norm: 1'b0};
        end
        expected_scores.push_back(s);
        dot_acc = 0;
        norm_a_acc = 0;
        norm_b_acc = 0;
    endtask

    // Driver: a new transfer is offered once the previous one has gone.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) accumulate_pair(cur_pair);
            if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle) begin
                cur_pair = pending_pairs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {cur_pair.label_b, cur_pair.label_a, cur_pair.elem_b,
                            cur_pair.elem_a};
                s_tlast <= cur_pair.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge aclk) begin
        score_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_scores.size() == 0) begin
                    $display("%0t: unexpected result sim=%0d flags=%b", $time,
                             $signed(m_tdata), m_tuser);
                    errors++;
                end else begin
                    want = expected_scores.pop_front();
                    if (m_tdata !== want.sim) begin
                        $display("%0t: similarity expected %0d actual %0d", $time,
                                 $signed(want.sim), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser[0] !== want.kept) begin
                        $display("%0t: edge_kept expected %b actual %b", $time,
                                 want.kept, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== want.zero_norm) begin
                        $display("%0t: zero_norm expected %b actual %b", $time,
                                 want.zero_norm, m_tuser[1]);
                        errors++;
                    end
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= 5000) begin
                $display("** cosine_similarity_label_decay: FAILED **");
                $finish;
            end
            m_tready <= $urandom_range(99) >= recv_idle;
        end
    end

    task automatic add_pair(input logic [15:0] ea, input logic [15:0] eb,
                            input logic [15:0] la, input logic [15:0] lb,
                            input logic last);
        pair_t p;
        p = '{last: last, label_b: lb, label_a: la, elem_b: eb, elem_a: ea};
        pending_pairs.push_back(p);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == csld_pkg::REG_DECAY_RATE) alpha = value;
        else thresh = value;
    endtask

    task automatic drain;
        wait (pending_pairs.size() == 0 && !s_tvalid && expected_scores.size() == 0);
        repeat (250) @(posedge aclk);
    endtask

    task automatic random_vectors(input int n_items);
        int left, len, mode;
        logic [15:0] ea, eb, la, lb;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
            mode = $urandom_range(9);
            la = $urandom;
            lb = ($urandom_range(3) == 0) ? 16'($urandom) : la + 16'($urandom_range(8));
            for (int i = 0; i < len; i++) begin
                ea = $urandom;
                case (mode)
                    0: eb = ea;
                    1: eb = -ea;
                    2: eb = 16'($urandom_range(3)) - 16'd1;
                    3: eb = ea + 16'($urandom_range(63));
                    default: eb = $urandom;
                endcase
                if ($urandom_range(15) == 0) ea = 16'd0;
                add_pair(ea, eb, (i == len - 1) ? la : 16'($urandom),
                         (i == len - 1) ? lb : 16'($urandom), i == len - 1);
            end
            left -= len;
        end
    endtask

    initial begin
        dot_acc = 0;
        norm_a_acc = 0;
        norm_b_acc = 0;
        send_idle = 9;
        recv_idle = 45;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        write_reg(csld_pkg::REG_DECAY_RATE, csld_pkg::DECAY_RATE_RESET);
        write_reg(csld_pkg::REG_KEEP_THRESHOLD, csld_pkg::KEEP_THRESHOLD_RESET);

        // Zero norms on both sides, then on either side.
        add_pair(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        add_pair(16'h1000, 16'd0, 16'd1, 16'd2, 1'b1);
        add_pair(16'd0, 16'h8000, 16'd1, 16'd2, 1'b1);
        // Parallel and anti-parallel vectors at the field extremes.
        add_pair(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_pair(16'h8000, 16'h8000, 16'd0, 16'd0, 1'b1);
        add_pair(16'h8000, 16'h7FFF, 16'd5, 16'd5, 1'b1);
        add_pair(16'h0001, 16'hFFFF, 16'd0, 16'd0, 1'b1);
        // Label distances from one to the full range.
        add_pair(16'h1234, 16'h2345, 16'd0, 16'd1, 1'b1);
        add_pair(16'h1234, 16'h2345, 16'd0, 16'd9, 1'b1);
        add_pair(16'h1234, 16'h2345, 16'hFFFF, 16'd0, 1'b1);
        // Orthogonal pair, and a negative result that falls below the threshold.
        add_pair(16'h1000, 16'd0, 16'hAAAA, 16'h5555, 1'b0);
        add_pair(16'd0, 16'h1000, 16'd3, 16'd3, 1'b1);
        add_pair(16'h4000, 16'hC000, 16'd7, 16'd2, 1'b1);
        // Long vectors of extreme values.
        for (int i = 0; i < 20; i++)
            add_pair(16'h8000, 16'h8000, 16'd0, 16'd0, i == 19);
        for (int i = 0; i < 20; i++)
            add_pair(16'h8000, 16'h7FFF, 16'd0, 16'd0, i == 19);
        random_vectors(110);
        drain();

        send_idle = 45;
        recv_idle = 9;
        write_reg(csld_pkg::REG_DECAY_RATE, 16'hFFFF);
        write_reg(csld_pkg::REG_KEEP_THRESHOLD, 16'h8000);
        random_vectors(110);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(csld_pkg::REG_DECAY_RATE, 16'd0);
        write_reg(csld_pkg::REG_KEEP_THRESHOLD, 16'h7FFF);
        random_vectors(60);
        drain();

        write_reg(csld_pkg::REG_DECAY_RATE, 16'd1200);
        write_reg(csld_pkg::REG_KEEP_THRESHOLD, -16'sd6000);
        random_vectors(110);
        drain();

        if (errors == 0) begin
            $display("** cosine_similarity_label_decay: PASSED **");
        end else begin
            $display("** cosine_similarity_label_decay: FAILED **");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
src/csld_pkg.sv
src/csld_acc.sv
src/csld_fin.sv
src/cosine_similarity_label_decay.sv
tb/tb_cosine_similarity_label_decay.sv
